// ===== design/mbrgf_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Modbus RTU gap framer.
package mbrgf_pkg;

  localparam int unsigned FrameMaxDefault = 512;
  localparam int unsigned OutBytesW = 10;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam logic [15:0] GapStartRst = 16'd50;
  localparam logic [15:0] GapMaxRst   = 16'd400;
  localparam logic [7:0]  GrowthRst   = 8'd5;

  // floor(y/100) = (y * DivMul) >> DivShift, exact for y < 2^18
  localparam logic [18:0] DivMul   = 19'd335545;
  localparam int unsigned DivShift = 25;

  typedef enum logic [1:0] {
    CFG_GAP_START = 2'd0,
    CFG_GAP_MAX   = 2'd1,
    CFG_GROWTH    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        we;
    logic [1:0]  idx;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rx_byte;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic [15:0] thr;      // current threshold
    logic [15:0] thr_rep;  // threshold after a reported frame
  } thr_status_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // old + max(1, floor(old*3/100)), i.e. max(old+1, floor(old*103/100))
  function automatic logic [16:0] thr_step(input logic [15:0] old);
    logic [17:0] y;
    logic [36:0] prod;
    logic [10:0] q;
    logic [10:0] inc;
    y    = {1'b0, old, 1'b0} + {2'b00, old};
    prod = 37'(y) * 37'(DivMul);
    q    = prod[DivShift +: 11];
    inc  = (q == 11'd0) ? 11'd1 : q;
    return {1'b0, old} + 17'(inc);
  endfunction

endpackage

// ===== design/modbus_rtu_gap_framer_crc_check_top.sv =====
// Top level of the Modbus RTU gap framer with CRC-16 check.
//
// Input channel (in_valid_i / in_stall_o): one event per transfer, either a
// received byte (kind_i = 0) or an idle poll (kind_i = 1), with its 32-bit
// microsecond time stamp. Output channel (out_valid_o / out_stall_i): one
// result per reported frame: length, received and computed CRC-16/Modbus,
// first/last byte times, close reason and the threshold after the update.
// Frames shorter than four bytes close without a result.
// A frame-closing event passes the input register, then the result register,
// before its result appears. Throughput: one event per cycle while no stalled
// result holds the flow; the loop through the frame state (gap compare, one CRC
// byte step, threshold step and its one small multiplier) is combinational.
// A stalled result holds in the result register while the next event waits
// in the input register; a further event is refused only when both are full.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 gap_start, also loading the threshold; 1 gap_max; 2 growth_every).
// Reset: empty frame, threshold 50, gap_max 400, growth_every 5, no results.
module modbus_rtu_gap_framer_crc_check_top import mbrgf_pkg::*; #(
  parameter int unsigned FRAME_MAX = FrameMaxDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 kind_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [31:0]          now_us_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OutBytesW-1:0] frame_bytes_o,
  output logic                 crc_good_o,
  output logic [15:0]          received_crc_o,
  output logic [15:0]          computed_crc_o,
  output logic [31:0]          first_time_o,
  output logic [31:0]          last_time_o,
  output logic                 buffer_full_o,
  output logic [15:0]          threshold_now_o
);

  item_t       in_item, held_item;
  logic        held_valid, advance, report;
  cfg_wr_t     cfg;
  thr_status_t thr;

  assign in_item.kind    = kind_i;
  assign in_item.rx_byte = rx_byte_i;
  assign in_item.now_us  = now_us_i;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  mbrgf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  mbrgf_gap_adapt u_gap_adapt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .report_i (report),
    .thr_o    (thr)
  );

  mbrgf_frame_core #(
    .FRAME_MAX (FRAME_MAX)
  ) u_frame_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (held_valid),
    .item_i          (held_item),
    .advance_o       (advance),
    .thr_i           (thr),
    .report_o        (report),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_bytes_o   (frame_bytes_o),
    .crc_good_o      (crc_good_o),
    .received_crc_o  (received_crc_o),
    .computed_crc_o  (computed_crc_o),
    .first_time_o    (first_time_o),
    .last_time_o     (last_time_o),
    .buffer_full_o   (buffer_full_o),
    .threshold_now_o (threshold_now_o)
  );

endmodule

// ===== design/mbrgf_in_stage.sv =====
// Input register stage: holds one event until the frame core takes it.
module mbrgf_in_stage import mbrgf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/mbrgf_gap_adapt.sv =====
// Configuration registers and the adaptive silence threshold.
module mbrgf_gap_adapt import mbrgf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_wr_t     cfg_i,
  input  logic        report_i,
  output thr_status_t thr_o
);

  logic [15:0] gap_max_q, gap_max_d;
  logic [7:0]  growth_q, growth_d;
  logic [15:0] thr_q, thr_d;
  logic [7:0]  fsg_q, fsg_d;

  logic [7:0]  fsg_inc;
  logic        hit;
  logic [16:0] step;
  logic [15:0] capped;
  logic [15:0] thr_rep;

  always_comb begin
    fsg_inc = fsg_q + 8'd1;
    hit     = (fsg_inc >= growth_q);
    step    = thr_step(thr_q);
    capped  = (step > {1'b0, gap_max_q}) ? gap_max_q : step[15:0];
    thr_rep = (hit && (thr_q < gap_max_q)) ? capped : thr_q;
  end

  always_comb begin
    gap_max_d = gap_max_q;
    growth_d  = growth_q;
    thr_d     = thr_q;
    fsg_d     = fsg_q;
    if (report_i) begin
      thr_d = thr_rep;
      fsg_d = hit ? 8'd0 : fsg_inc;
    end
    if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_GAP_START: thr_d     = cfg_i.data;
        CFG_GAP_MAX:   gap_max_d = cfg_i.data;
        CFG_GROWTH:    growth_d  = cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_max_q <= GapMaxRst;
      growth_q  <= GrowthRst;
      thr_q     <= GapStartRst;
      fsg_q     <= 8'd0;
    end else begin
      gap_max_q <= gap_max_d;
      growth_q  <= growth_d;
      thr_q     <= thr_d;
      fsg_q     <= fsg_d;
    end
  end

  assign thr_o.thr     = thr_q;
  assign thr_o.thr_rep = thr_rep;

  // a step never lowers the threshold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_i && !cfg_i.we |=> thr_q >= $past(thr_q))
    else $error("threshold decreased on a frame report");

  // the stepped value never exceeds the ceiling when it moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_i && !cfg_i.we && (thr_rep != thr_q) |-> thr_rep <= gap_max_q)
    else $error("threshold step exceeded gap_max");

endmodule

// ===== design/mbrgf_frame_core.sv =====
// Frame state, close detection, running CRC and the result register.
module mbrgf_frame_core import mbrgf_pkg::*; #(
  parameter int unsigned FRAME_MAX = FrameMaxDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  item_t                item_i,
  output logic                 advance_o,
  input  thr_status_t          thr_i,
  output logic                 report_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OutBytesW-1:0] frame_bytes_o,
  output logic                 crc_good_o,
  output logic [15:0]          received_crc_o,
  output logic [15:0]          computed_crc_o,
  output logic [31:0]          first_time_o,
  output logic [31:0]          last_time_o,
  output logic                 buffer_full_o,
  output logic [15:0]          threshold_now_o
);

  localparam int unsigned CntW = $clog2(FRAME_MAX + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(FRAME_MAX);
  localparam logic [CntW-1:0] CntMin = CntW'(4);
  localparam logic [CntW-1:0] CntTwo = CntW'(2);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  logic [CntW-1:0] total_q, total_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      tail0_q, tail0_d, tail1_q, tail1_d;
  logic [31:0]     start_q, start_d, latest_q, latest_d;

  logic                 out_valid_q, out_valid_d;
  logic [OutBytesW-1:0] out_bytes_q;
  logic                 out_good_q, out_full_q;
  logic [15:0]          out_rx_q, out_crc_q, out_thr_q;
  logic [31:0]          out_first_q, out_last_q;

  logic [31:0] elapsed;
  logic        is_byte, gap_close, full_close, closing, report;
  logic [15:0] rx_crc;

  assign advance_o = item_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    elapsed    = item_i.now_us - latest_q;
    is_byte    = (item_i.kind == 1'b0);
    gap_close  = (total_q != '0) && (elapsed >= {16'h0000, thr_i.thr});
    full_close = is_byte && !gap_close && (total_q >= CntMax);
    closing    = gap_close || full_close;
    report     = closing && (total_q >= CntMin);
    rx_crc     = {tail1_q, tail0_q};
  end

  assign report_o = advance_o && report;

  always_comb begin
    total_d  = total_q;
    crc_d    = crc_q;
    tail0_d  = tail0_q;
    tail1_d  = tail1_q;
    start_d  = start_q;
    latest_d = latest_q;
    if (advance_o) begin
      if (is_byte) begin
        if (closing || (total_q == '0)) begin
          // byte opens a new frame
          total_d  = CntOne;
          crc_d    = CrcInit;
          tail0_d  = 8'h00;
          tail1_d  = item_i.rx_byte;
          start_d  = item_i.now_us;
          latest_d = item_i.now_us;
        end else begin
          // CRC trails by two bytes so the received CRC never enters it
          if (total_q >= CntTwo) begin
            crc_d = crc_feed(crc_q, tail0_q);
          end
          tail0_d  = tail1_q;
          tail1_d  = item_i.rx_byte;
          total_d  = total_q + CntOne;
          latest_d = item_i.now_us;
        end
      end else if (closing) begin
        total_d  = '0;
        crc_d    = CrcInit;
        tail0_d  = 8'h00;
        tail1_d  = 8'h00;
        start_d  = 32'h0;
        latest_d = 32'h0;
      end
    end
  end

  assign out_valid_d = advance_o ? report : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      crc_q       <= CrcInit;
      tail0_q     <= 8'h00;
      tail1_q     <= 8'h00;
      start_q     <= 32'h0;
      latest_q    <= 32'h0;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      crc_q       <= crc_d;
      tail0_q     <= tail0_d;
      tail1_q     <= tail1_d;
      start_q     <= start_d;
      latest_q    <= latest_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (report_o) begin
      out_bytes_q <= OutBytesW'(total_q);
      out_good_q  <= (rx_crc == crc_q);
      out_rx_q    <= rx_crc;
      out_crc_q   <= crc_q;
      out_first_q <= start_q;
      out_last_q  <= latest_q;
      out_full_q  <= full_close;
      out_thr_q   <= thr_i.thr_rep;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_bytes_o   = out_bytes_q;
  assign crc_good_o      = out_good_q;
  assign received_crc_o  = out_rx_q;
  assign computed_crc_o  = out_crc_q;
  assign first_time_o    = out_first_q;
  assign last_time_o     = out_last_q;
  assign buffer_full_o   = out_full_q;
  assign threshold_now_o = out_thr_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntMax)
    else $error("byte count beyond FRAME_MAX");

  // nothing is folded into the CRC until a third byte arrives
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntTwo |-> crc_q == CrcInit)
    else $error("CRC moved before two bytes were held back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_o |=> out_valid_q && (out_crc_q == $past(crc_q)))
    else $error("reported frame not captured in result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && is_byte |=> total_q != '0)
    else $error("byte transfer left the frame empty");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the Modbus RTU gap framer: predicted frame reports vs. result channel.
module testbench;
  import mbrgf_pkg::*;

  localparam int unsigned FRAME_LIMIT = FrameMaxDefault;
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POLL = 1'b1;
  localparam int SETTLE_CYCLES = 6;
  localparam int STUCK_LIMIT = 1000;
  localparam int LONG_HOLD_AT = 50;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [OutBytesW-1:0] frame_bytes;
    logic                 crc_good;
    logic [15:0]          received_crc;
    logic [15:0]          computed_crc;
    logic [31:0]          first_time;
    logic [31:0]          last_time;
    logic                 buffer_full;
    logic [15:0]          threshold_now;
  } frame_report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [1:0]           cfg_idx_i = CFG_GAP_START;
  logic [15:0]          cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 kind_i = KIND_POLL;
  logic [7:0]           rx_byte_i = '0;
  logic [31:0]          now_us_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [OutBytesW-1:0] frame_bytes_o;
  logic                 crc_good_o;
  logic [15:0]          received_crc_o;
  logic [15:0]          computed_crc_o;
  logic [31:0]          first_time_o;
  logic [31:0]          last_time_o;
  logic                 buffer_full_o;
  logic [15:0]          threshold_now_o;

  modbus_rtu_gap_framer_crc_check_top #(
    .FRAME_MAX(FRAME_LIMIT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .rx_byte_i      (rx_byte_i),
    .now_us_i       (now_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_bytes_o  (frame_bytes_o),
    .crc_good_o     (crc_good_o),
    .received_crc_o (received_crc_o),
    .computed_crc_o (computed_crc_o),
    .first_time_o   (first_time_o),
    .last_time_o    (last_time_o),
    .buffer_full_o  (buffer_full_o),
    .threshold_now_o(threshold_now_o)
  );

  always #5 clk_i = ~clk_i;

  // Frame tracker state and its copy of the registers
  int unsigned   fr_count;
  logic [15:0]   fr_crc;
  logic [7:0]    fr_older;
  logic [7:0]    fr_newer;
  logic [31:0]   fr_first;
  logic [31:0]   fr_last;
  logic [15:0]   gap_now;
  logic [7:0]    reported_since_step;
  logic [15:0]   set_gap_start;
  logic [15:0]   set_gap_max;
  logic [7:0]    set_growth;

  frame_report_t reports_due[$];
  item_t         events_pending[$];

  logic [31:0]   clock_us;
  int            queued;
  logic          calm_tail = 1'b0;
  int            events_accepted;
  int            mismatches;
  logic [15:0]   directed_crc;

  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  function automatic void clear_held_frame();
    fr_count = 0;
    fr_crc   = CrcInit;
    fr_older = '0;
    fr_newer = '0;
    fr_first = '0;
    fr_last  = '0;
  endfunction

  function automatic void reset_tracker();
    set_gap_start = GapStartRst;
    set_gap_max   = GapMaxRst;
    set_growth    = GrowthRst;
    gap_now       = GapStartRst;
    reported_since_step = '0;
    clear_held_frame();
  endfunction

  function automatic void close_held_frame(input logic full);
    frame_report_t rep;
    int unsigned   grown;
    if (fr_count >= 4) begin
      reported_since_step = reported_since_step + 8'd1;
      if (reported_since_step >= set_growth) begin
        reported_since_step = '0;
        // at or above the ceiling the value stays, the counter still restarts
        if (gap_now < set_gap_max) begin
          grown = (32'(gap_now) * 103) / 100;
          if (grown <= gap_now) grown = gap_now + 1;
          if (grown > set_gap_max) grown = set_gap_max;
          gap_now = grown[15:0];
        end
      end
      rep.frame_bytes   = fr_count[OutBytesW-1:0];
      rep.received_crc  = {fr_newer, fr_older};
      rep.computed_crc  = fr_crc;
      rep.crc_good      = (rep.received_crc == fr_crc);
      rep.first_time    = fr_first;
      rep.last_time     = fr_last;
      rep.buffer_full   = full;
      rep.threshold_now = gap_now;
      reports_due.push_back(rep);
    end
    clear_held_frame();
  endfunction

  function automatic void predict_framer_event(input item_t ev);
    // silence close first, so a byte on a full buffer then finds it empty
    if (fr_count > 0 && (ev.now_us - fr_last) >= 32'(gap_now)) close_held_frame(1'b0);
    if (ev.kind == KIND_BYTE) begin
      if (fr_count >= FRAME_LIMIT) close_held_frame(1'b1);
      if (fr_count == 0) fr_first = ev.now_us;
      if (fr_count >= 2) fr_crc = modbus_crc_byte(fr_crc, fr_older);
      fr_older = fr_newer;
      fr_newer = ev.rx_byte;
      fr_count++;
      fr_last = ev.now_us;
    end
  endfunction

  function automatic string report_text(input frame_report_t r);
    return $sformatf("len=%0d ok=%0b rx=%h calc=%h first=%h last=%h full=%0b gap=%0d",
                     r.frame_bytes, r.crc_good, r.received_crc, r.computed_crc,
                     r.first_time, r.last_time, r.buffer_full, r.threshold_now);
  endfunction

  function automatic logic idling_on();
    // idle-free stretch once every 256 transfers, and none at the tail
    return !calm_tail && (events_accepted[7:6] != 2'b11);
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GAP_START: begin
        set_gap_start = value;
        gap_now       = value;
      end
      CFG_GAP_MAX: set_gap_max = value;
      CFG_GROWTH:  set_growth = value[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (events_pending.size() != 0 || in_valid_i || reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_event(input logic kind, input logic [7:0] b, input logic [31:0] delta);
    clock_us = clock_us + delta;
    events_pending.push_back(item_t'{kind, b, clock_us});
    queued++;
  endtask

  function automatic logic [31:0] inner_delta();
    int unsigned span;
    int unsigned pick;
    span = (set_gap_start == 0) ? 0 : set_gap_start - 1;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom_range(0, (span < 20) ? span : 20);
    if (pick < 9) return $urandom_range(0, span);
    return span;
  endfunction

  function automatic logic [31:0] long_silence();
    int unsigned top;
    top = (set_gap_start > set_gap_max) ? set_gap_start : set_gap_max;
    return top + $urandom_range(0, 3000);
  endfunction

  function automatic logic [15:0] pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom_range(1, 200));
    if (r < 8) return 16'($urandom_range(1, 2000));
    return 16'($urandom_range(1, 65535));
  endfunction

  // Bytes stay closer together than gap_start; polls may fall between them.
  task automatic queue_frame(input int len, input bit crc_ok, input logic [31:0] lead);
    logic [15:0] crc;
    logic [7:0]  b;
    logic [31:0] d;
    logic [31:0] p;
    crc = CrcInit;
    for (int i = 0; i < len; i++) begin
      if (crc_ok && len >= 3 && i == len - 2) b = crc[7:0];
      else if (crc_ok && len >= 3 && i == len - 1) b = crc[15:8];
      else begin
        b = 8'($urandom_range(0, 255));
        crc = modbus_crc_byte(crc, b);
      end
      d = (i == 0) ? lead : inner_delta();
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        p = $urandom_range(0, d);
        put_event(KIND_POLL, 8'($urandom_range(0, 255)), p);
        d = d - p;
      end
      put_event(KIND_BYTE, b, d);
    end
  endtask

  task automatic random_traffic(input int n);
    int          stop_at;
    int          r;
    int          len;
    logic [31:0] lead;
    stop_at = queued + n;
    while (queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        clock_us = $urandom;
        put_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 0);
      end else begin
        lead = long_silence();
        r = $urandom_range(0, 99);
        if (r < 4) clock_us = $urandom;
        else if (r < 8) clock_us = 32'hFFFF_FFFF - $urandom_range(0, 60) - lead;
        r = $urandom_range(0, 99);
        if (r < 12) len = $urandom_range(1, 3);
        else if (r < 80) len = $urandom_range(4, 10);
        else len = $urandom_range(11, 40);
        queue_frame(len, $urandom_range(0, 9) < 6, lead);
        r = $urandom_range(0, 9);
        if (r < 4) put_event(KIND_POLL, 8'($urandom_range(0, 255)), long_silence());
        else if (r < 6) put_event(KIND_POLL, 8'($urandom_range(0, 255)), 32'(set_gap_start));
      end
    end
  endtask

  // Input driver
  int    send_gap;
  item_t next_event;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      send_gap        <= 0;
      events_accepted <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_framer_event(item_t'{kind_i, rx_byte_i, now_us_i});
        events_accepted <= events_accepted + 1;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (events_pending.size() > 0) begin
          next_event = events_pending.pop_front();
          kind_i     <= next_event.kind;
          rx_byte_i  <= next_event.rx_byte;
          now_us_i   <= next_event.now_us;
          in_valid_i <= 1'b1;
          if (idling_on() && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result-side stall
  int   sink_hold;
  logic long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      sink_hold      <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && events_accepted >= LONG_HOLD_AT) begin
      // long hold-off so the block backs up and stalls its input
      long_hold_done <= 1'b1;
      sink_hold      <= LONG_HOLD_CYCLES;
      out_stall_i    <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold   <= sink_hold - 1;
      out_stall_i <= (sink_hold > 1);
    end else if (idling_on() && $urandom_range(0, 7) == 0) begin
      sink_hold   <= $urandom_range(1, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result monitor
  frame_report_t seen;
  frame_report_t wanted;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{frame_bytes_o, crc_good_o, received_crc_o, computed_crc_o,
               first_time_o, last_time_o, buffer_full_o, threshold_now_o};
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected frame report: %s", report_text(seen));
      end else begin
        wanted = reports_due.pop_front();
        if (seen !== wanted) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("frame report mismatch");
            $display("  expected %s", report_text(wanted));
            $display("  actual   %s", report_text(seen));
          end
        end
      end
    end
  end

  // Watchdog: cycles without a transfer on either side
  int stuck_cycles;

  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    reset_tracker();
    clock_us   = '0;
    queued     = 0;
    mismatches = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: directed corner cases
    put_event(KIND_POLL, 8'hFF, 0);       // poll with nothing held
    directed_crc = modbus_crc_byte(modbus_crc_byte(CrcInit, 8'h00), 8'hFF);
    put_event(KIND_BYTE, 8'h00, 10);
    put_event(KIND_BYTE, 8'hFF, 49);
    put_event(KIND_POLL, 8'h00, 49);      // one below the threshold: frame stays open
    put_event(KIND_BYTE, directed_crc[7:0], 0);
    put_event(KIND_BYTE, directed_crc[15:8], 49);
    put_event(KIND_POLL, 8'hFF, 50);      // exactly at the threshold: closes
    put_event(KIND_BYTE, 8'hFF, 100);
    put_event(KIND_BYTE, 8'hFF, 0);
    put_event(KIND_BYTE, 8'hFF, 0);
    put_event(KIND_BYTE, 8'h00, 50);      // drops the 3-byte frame, opens a new one
    put_event(KIND_BYTE, 8'hFF, 1);
    put_event(KIND_BYTE, 8'h00, 1);
    put_event(KIND_BYTE, 8'hFF, 1);
    clock_us = 32'hFFFF_FFE0;             // frame that straddles the timestamp wrap
    put_event(KIND_BYTE, 8'hA5, 0);
    put_event(KIND_BYTE, 8'h5A, 31);
    put_event(KIND_POLL, 8'h00, 10);
    put_event(KIND_BYTE, 8'h01, 16);
    put_event(KIND_BYTE, 8'h80, 49);
    put_event(KIND_POLL, 8'h7F, 65535);
    random_traffic(60);
    wait_idle();

    write_reg(CFG_GAP_START, 16'd1);
    write_reg(CFG_GAP_MAX, 16'hFFFF);
    write_reg(CFG_GROWTH, 16'd1);
    random_traffic(60);
    wait_idle();

    // threshold sits at its ceiling
    write_reg(CFG_GAP_START, 16'd300);
    write_reg(CFG_GAP_MAX, 16'd300);
    random_traffic(40);
    wait_idle();

    write_reg(CFG_GAP_START, 16'hFFFF);
    write_reg(CFG_GAP_MAX, 16'd1);
    write_reg(CFG_GROWTH, 16'd2);
    random_traffic(40);
    wait_idle();

    // zero threshold closes after every byte; zero growth steps on every report
    write_reg(CFG_GAP_START, 16'd0);
    write_reg(CFG_GAP_MAX, 16'd500);
    write_reg(CFG_GROWTH, 16'd0);
    random_traffic(20);
    wait_idle();
    write_reg(CFG_GAP_START, 16'd20);
    random_traffic(40);
    wait_idle();

    // growth_every lowered below the running count
    write_reg(CFG_GAP_START, 16'd100);
    write_reg(CFG_GAP_MAX, 16'd2000);
    write_reg(CFG_GROWTH, 16'd200);
    random_traffic(50);
    wait_idle();
    write_reg(CFG_GROWTH, 16'd3);
    random_traffic(30);
    wait_idle();

    // full buffer: length close keeps the byte as the start of the next frame
    write_reg(CFG_GAP_START, 16'd1000);
    write_reg(CFG_GAP_MAX, 16'd1000);
    write_reg(CFG_GROWTH, 16'd5);
    queue_frame(FRAME_LIMIT + 3, 1'b0, long_silence());
    put_event(KIND_POLL, 8'h00, long_silence());
    wait_idle();

    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_GAP_START, pick_gap());
      write_reg(CFG_GAP_MAX, pick_gap());
      write_reg(CFG_GROWTH, 16'((($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                             : $urandom_range(0, 255))));
      if (k == 3) calm_tail = 1'b1;
      random_traffic(50);
      wait_idle();
    end

    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
